[design/pdm_pkg.sv]
`default_nettype none

package pdm_pkg;

  // coordinate and result widths
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned DIFF_W      = 32;
  localparam int unsigned DIST_W      = 33;
  localparam int unsigned SQ_W        = 2 * DIFF_W;
  // radicand padded to an even bit count, one root bit per stage
  localparam int unsigned RAD_W       = 66;
  localparam int unsigned ROOT_STAGES = RAD_W / 2;
  localparam int unsigned REM_W       = 35;

  // metric selector codes
  typedef enum logic [1:0] {
    METRIC_EUCLID = 2'd0,
    METRIC_CHEB   = 2'd1,
    METRIC_MANH   = 2'd2,
    METRIC_BAD    = 2'd3
  } metric_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    metric_t           sel;
  } pdm_item_t;

endpackage

`default_nettype wire

[design/planar_distance_metric_unit_top.sv]
// From input accept an item passes the queue, then the operand, squares, sum, root-stage and result registers.
// Throughput: one item per cycle while the output is not stalled, set by the 33-stage pipelined square root.
// Non-Euclidean metrics ride the same pipeline, so results leave in input order.
// A small item queue parts the input side from the compute pipeline.
// Synchronous reset clears queue pointers and pipeline valids; data regs are not reset.
`default_nettype none

module planar_distance_metric_unit_top import pdm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DIST_W-1:0]         distance,
  output logic                      bad_select
);

  logic      push_valid, push_ready;
  pdm_item_t push_item;
  logic      pop_valid, pop_ready;
  pdm_item_t pop_item;

  pdm_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .ax         (ax),
    .ay         (ay),
    .bx         (bx),
    .by         (by),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pdm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pop_valid),
    .in_ready   (pop_ready),
    .in_item    (pop_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .distance   (distance),
    .bad_select (bad_select)
  );

endmodule

`default_nettype wire

[design/pdm_front.sv]
`default_nettype none

module pdm_front import pdm_pkg::*; (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  output logic                      push_valid,
  input  logic                      push_ready,
  output pdm_item_t                 push_item
);

  logic [COORD_W:0] diff_x, diff_y;
  logic [COORD_W:0] mag_x, mag_y;

  // full-precision signed differences, then magnitude
  always_comb begin
    diff_x = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
    diff_y = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
    mag_x  = diff_x[COORD_W] ? (~diff_x + (COORD_W+1)'(1)) : diff_x;
    mag_y  = diff_y[COORD_W] ? (~diff_y + (COORD_W+1)'(1)) : diff_y;
  end

  // item goes straight into the queue
  assign push_item.dx  = mag_x[DIFF_W-1:0];
  assign push_item.dy  = mag_y[DIFF_W-1:0];
  assign push_item.sel = metric_t'(func);
  assign push_valid    = in_valid;
  assign in_ready      = push_ready;

endmodule

`default_nettype wire

[design/pdm_queue.sv]
`default_nettype none

module pdm_queue import pdm_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  pdm_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output pdm_item_t pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pdm_item_t         mem [0:DEPTH-1];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CW'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

[design/pdm_back.sv]
`default_nettype none

module pdm_back import pdm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pdm_item_t         in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] distance,
  output logic              bad_select
);

  // operand, products, sum, root stages, output
  localparam int unsigned PIPE_LEN = ROOT_STAGES + 4;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIST_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic              euc;
    logic              bad;
    logic [DIST_W-1:0] alt;
  } root_stage_t;

  logic [PIPE_LEN-1:0] vld;
  logic                adv;
  pdm_item_t           op;
  logic [SQ_W-1:0]     sq_x, sq_y;
  logic [DIST_W-1:0]   alt1;
  logic                euc1, bad1;
  root_stage_t         st [0:ROOT_STAGES];

  // whole pipe moves unless the result waits
  assign adv       = !vld[PIPE_LEN-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LEN-2:0], in_valid};
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (adv) begin
      op <= in_item;
    end
  end

  // squares, plus the non-Euclidean metrics
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x <= op.dx * op.dx;
      sq_y <= op.dy * op.dy;
      euc1 <= (op.sel == METRIC_EUCLID);
      bad1 <= (op.sel == METRIC_BAD);
      case (op.sel)
        METRIC_CHEB: begin
          alt1 <= (op.dx > op.dy) ? {1'b0, op.dx} : {1'b0, op.dy};
        end
        METRIC_MANH: begin
          alt1 <= {1'b0, op.dx} + {1'b0, op.dy};
        end
        default: begin
          alt1 <= '0;
        end
      endcase
    end
  end

  // sum of squares seeds the root pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].rad  <= {1'b0, {1'b0, sq_x} + {1'b0, sq_y}};
      st[0].rem  <= '0;
      st[0].root <= '0;
      st[0].euc  <= euc1;
      st[0].bad  <= bad1;
      st[0].alt  <= alt1;
    end
  end

  // restoring square root, one root bit per stage
  for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_root
    logic [REM_W+1:0] rem_sh, trial, rem_sub;
    logic             take;

    always_comb begin
      rem_sh  = {st[i].rem, st[i].rad[RAD_W-1 -: 2]};
      trial   = {2'b00, st[i].root, 2'b01};
      rem_sub = rem_sh - trial;
      take    = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i+1].rem  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        st[i+1].root <= {st[i].root[DIST_W-2:0], take};
        st[i+1].rad  <= {st[i].rad[RAD_W-3:0], 2'b00};
        st[i+1].euc  <= st[i].euc;
        st[i+1].bad  <= st[i].bad;
        st[i+1].alt  <= st[i].alt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      distance   <= st[ROOT_STAGES].euc ? st[ROOT_STAGES].root : st[ROOT_STAGES].alt;
      bad_select <= st[ROOT_STAGES].bad;
    end
  end

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_select |-> distance == '0)
    else $error("bad selector gave nonzero distance");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire
